/* design/table_interpolation_lookup_core_assert.svh */
// Assertion macros used by the table interpolation lookup core.
`ifndef TABLE_INTERPOLATION_LOOKUP_CORE_ASSERT_SVH
`define TABLE_INTERPOLATION_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TILU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TILU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tilu_pkg.sv */
// Package: types, field layout and sizing constants of the table interpolation lookup.
package tilu_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int POS_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 11;
  localparam int EIDX_W   = 10;
  localparam int LP_W     = 10;
  localparam int STATUS_W = 2;
  localparam int PROD_W   = 64;
  localparam int EXT_W    = 32;

  localparam int ENTRY_W = POS_W + 2 * VAL_W;

  // Slave tdata layout, lowest bit first
  localparam int EI_LSB    = 0;
  localparam int EP_LSB    = EI_LSB + EIDX_W;
  localparam int VA_LSB    = EP_LSB + POS_W;
  localparam int VB_LSB    = VA_LSB + VAL_W;
  localparam int QP_LSB    = VB_LSB + VAL_W;
  localparam int S_FIELD_W = QP_LSB + POS_W;
  localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

  // Master tdata layout
  localparam int M_FIELD_W = 2 * VAL_W + LP_W;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_SHORT      = 2'd1,
    ST_ZERO_WIDTH = 2'd2
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_b;
    logic [VAL_W-1:0] value_a;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage

/* design/tilu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module tilu_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tilu_div.sv */
// Radix-4 restoring divider: 64-bit dividend by 32-bit divisor, two quotient bits per cycle.
module tilu_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tilu_pkg::PROD_W-1:0]  dividend,
  input  logic [tilu_pkg::POS_W-1:0]   divisor,
  output logic                         done,
  output logic [tilu_pkg::PROD_W-1:0]  quotient
);

  localparam int STEPS  = tilu_pkg::PROD_W / 2;
  localparam int STEP_W = $clog2(STEPS);
  localparam int D_W    = tilu_pkg::POS_W;

  logic [D_W-1:0]              rem;
  logic [D_W-1:0]              dvs;
  logic [tilu_pkg::PROD_W-1:0] quo;
  logic [STEP_W-1:0]           cnt;
  logic                        busy;

  logic [D_W:0]   t1, t2;
  logic           ge1, ge2;
  logic [D_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem, quo[tilu_pkg::PROD_W-1]};
    ge1 = t1 >= {1'b0, dvs};
    r1  = ge1 ? D_W'(t1 - {1'b0, dvs}) : t1[D_W-1:0];
    t2  = {r1, quo[tilu_pkg::PROD_W-2]};
    ge2 = t2 >= {1'b0, dvs};
    r2  = ge2 ? D_W'(t2 - {1'b0, dvs}) : t2[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[tilu_pkg::PROD_W-3:0], ge1, ge2};
        rem <= r2;
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* design/table_interpolation_lookup_core.sv */
// Sequence: a load is written to the table RAM when accepted; a query runs a search of
// k = ceil(log2(n - 1)) steps over n = min(point_count, depth) points, reads the two
// interval points, multiplies and divides; a zero-width interval answers after the point
// reads, a short table without a search. Throughput: one load per cycle while idle; one
// query at a time, the next transaction is taken once the query result is registered,
// paced by the table RAM read port and the 2-bit-per-cycle divider.
// Reset: rst (synchronous) clears point_count, the sequencer and the output valid;
// table contents are not cleared and are undefined until loaded.
`include "table_interpolation_lookup_core_assert.svh"

module table_interpolation_lookup_core (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // {pad, query_pos, entry_value_b, entry_value_a, entry_pos, entry_index} from bit 0:
  // entry_index[9:0], entry_pos[41:10], entry_value_a[73:42], entry_value_b[105:74],
  // query_pos[137:106]
  input  logic [tilu_pkg::S_TDATA_W-1:0] s_tdata,
  // op[0]
  input  logic [0:0]                     s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // result_a[31:0], result_b[63:32], lower_point[73:64], zero pad above
  output logic [tilu_pkg::M_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [tilu_pkg::STATUS_W-1:0]  m_tuser,
  // point_count write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tilu_pkg::CNT_W-1:0]     cfg_data
);

  localparam int IDX_W = tilu_pkg::IDX_W;
  localparam int EXT_W = tilu_pkg::EXT_W;
  localparam int VAL_W = tilu_pkg::VAL_W;
  localparam int POS_W = tilu_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,   // issue probe read (or read of lo once the interval is found)
    S_SWAIT,    // probe data back: narrow the interval
    S_RD1,      // capture lower point, read upper point
    S_RD2,      // capture upper point
    S_PREP,     // differences, magnitudes, signs
    S_MULA,
    S_MULB,
    S_DSTART,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  // ---------------- input unpack ----------------
  tilu_pkg::op_t          in_op;
  logic [tilu_pkg::EIDX_W-1:0] in_entry_index;
  logic [POS_W-1:0]       in_entry_pos;
  logic [VAL_W-1:0]       in_value_a;
  logic [VAL_W-1:0]       in_value_b;
  logic [POS_W-1:0]       in_query_pos;
  logic                   in_accept;
  logic [EXT_W-1:0]       in_idx_ext;
  logic                   in_range;

  assign in_op          = tilu_pkg::op_t'(s_tuser[0]);
  assign in_entry_index = s_tdata[tilu_pkg::EI_LSB +: tilu_pkg::EIDX_W];
  assign in_entry_pos   = s_tdata[tilu_pkg::EP_LSB +: POS_W];
  assign in_value_a     = s_tdata[tilu_pkg::VA_LSB +: VAL_W];
  assign in_value_b     = s_tdata[tilu_pkg::VB_LSB +: VAL_W];
  assign in_query_pos   = s_tdata[tilu_pkg::QP_LSB +: POS_W];

  assign s_tready   = (state == S_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign in_idx_ext = EXT_W'(in_entry_index);
  assign in_range   = in_idx_ext < EXT_W'(tilu_pkg::TABLE_DEPTH);

  // ---------------- config ----------------
  logic [tilu_pkg::CNT_W-1:0] point_count;
  logic [EXT_W-1:0]           pc_ext;
  logic [EXT_W-1:0]           n_pts;

  assign cfg_ready = 1'b1;
  assign pc_ext    = EXT_W'(point_count);
  // counts above the table depth search the whole table
  assign n_pts     = (pc_ext > EXT_W'(tilu_pkg::TABLE_DEPTH)) ?
                     EXT_W'(tilu_pkg::TABLE_DEPTH) : pc_ext;

  // ---------------- table RAM ----------------
  logic                              ram_we;
  tilu_pkg::entry_t                  ram_wentry;
  logic                              ram_re;
  logic [IDX_W-1:0]                  ram_raddr;
  logic [tilu_pkg::ENTRY_W-1:0]      ram_rdata;
  tilu_pkg::entry_t                  rd_entry;

  assign ram_we     = in_accept && (in_op == tilu_pkg::OP_LOAD) && in_range;
  assign ram_wentry = '{value_b: in_value_b, value_a: in_value_a, pos: in_entry_pos};
  assign rd_entry   = tilu_pkg::entry_t'(ram_rdata);

  tilu_ram #(
    .WIDTH (tilu_pkg::ENTRY_W),
    .DEPTH (tilu_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx_ext[IDX_W-1:0]),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- search control ----------------
  logic [POS_W-1:0] q;
  logic [IDX_W-1:0] lo, hi;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] lo_inc;
  logic             search_go;
  logic [EXT_W-1:0] lo_ext;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[IDX_W:1];
  assign lo_inc    = lo + IDX_W'(1);
  assign search_go = {1'b0, hi} > ({1'b0, lo} + (IDX_W + 1)'(1));
  assign lo_ext    = EXT_W'(lo);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = lo;
    unique case (state)
      S_SEARCH: begin
        ram_re    = 1'b1;
        ram_raddr = search_go ? mid : lo;
      end
      S_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = lo_inc;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = lo;
      end
    endcase
  end

  // ---------------- interval arithmetic ----------------
  logic [POS_W-1:0] x0, x1;
  logic [VAL_W-1:0] y0a, y0b, y1a, y1b;

  logic [POS_W:0]   dq_s, dx_s;
  logic [VAL_W:0]   dya_s, dyb_s;
  logic [POS_W-1:0] dq_mag_c, dx_mag_c;
  logic [VAL_W-1:0] dya_mag_c, dyb_mag_c;

  // signed differences, one bit wider than the operands
  always_comb begin
    dq_s      = {1'b0, q} - {1'b0, x0};
    dx_s      = {1'b0, x1} - {1'b0, x0};
    dya_s     = {y1a[VAL_W-1], y1a} - {y0a[VAL_W-1], y0a};
    dyb_s     = {y1b[VAL_W-1], y1b} - {y0b[VAL_W-1], y0b};
    dq_mag_c  = dq_s[POS_W]  ? POS_W'(-dq_s)  : dq_s[POS_W-1:0];
    dx_mag_c  = dx_s[POS_W]  ? POS_W'(-dx_s)  : dx_s[POS_W-1:0];
    dya_mag_c = dya_s[VAL_W] ? VAL_W'(-dya_s) : dya_s[VAL_W-1:0];
    dyb_mag_c = dyb_s[VAL_W] ? VAL_W'(-dyb_s) : dyb_s[VAL_W-1:0];
  end

  logic [POS_W-1:0]            dq_mag, dx_mag;
  logic [VAL_W-1:0]            dya_mag, dyb_mag;
  logic                        neg_a, neg_b;
  logic [tilu_pkg::PROD_W-1:0] prod_a, prod_b;

  // ---------------- dividers ----------------
  logic                        div_start;
  logic                        done_a, done_b;
  logic [tilu_pkg::PROD_W-1:0] quot_a, quot_b;

  assign div_start = (state == S_DSTART);

  tilu_div u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_a),
    .divisor  (dx_mag),
    .done     (done_a),
    .quotient (quot_a)
  );

  tilu_div u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_b),
    .divisor  (dx_mag),
    .done     (done_b),
    .quotient (quot_b)
  );

  // y0 +/- quotient, saturated; quotients past 2^33 saturate outright
  function automatic logic [VAL_W-1:0] finish_val(
    input logic [tilu_pkg::PROD_W-1:0] quot,
    input logic [VAL_W-1:0]            y0,
    input logic                        neg
  );
    logic signed [35:0] y0x;
    logic signed [35:0] qx;
    logic signed [35:0] r;
    y0x = {{4{y0[VAL_W-1]}}, y0};
    qx  = {2'b00, quot[33:0]};
    r   = neg ? (y0x - qx) : (y0x + qx);
    if (quot > 64'h0000_0002_0000_0000) begin
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (r > $signed(36'h0_7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end
    if (r < $signed(36'hF_8000_0000)) begin
      return 32'h8000_0000;
    end
    return r[VAL_W-1:0];
  endfunction

  // ---------------- sequencer ----------------
  logic [VAL_W-1:0]  res_a, res_b;
  tilu_pkg::status_t res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        point_count <= cfg_data;
      end
      // S_DONE refills the output register on its own
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept && (in_op == tilu_pkg::OP_QUERY)) begin
            q  <= in_query_pos;
            lo <= '0;
            hi <= IDX_W'(n_pts - EXT_W'(1));
            if (n_pts < EXT_W'(2)) begin
              res_a      <= '0;
              res_b      <= '0;
              res_status <= tilu_pkg::ST_SHORT;
              state      <= S_DONE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          state <= search_go ? S_SWAIT : S_RD1;
        end
        S_SWAIT: begin
          if (q < rd_entry.pos) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
          state <= S_SEARCH;
        end
        S_RD1: begin
          x0    <= rd_entry.pos;
          y0a   <= rd_entry.value_a;
          y0b   <= rd_entry.value_b;
          state <= S_RD2;
        end
        S_RD2: begin
          x1    <= rd_entry.pos;
          y1a   <= rd_entry.value_a;
          y1b   <= rd_entry.value_b;
          state <= S_PREP;
        end
        S_PREP: begin
          dq_mag  <= dq_mag_c;
          dx_mag  <= dx_mag_c;
          dya_mag <= dya_mag_c;
          dyb_mag <= dyb_mag_c;
          neg_a   <= dq_s[POS_W] ^ dya_s[VAL_W] ^ dx_s[POS_W];
          neg_b   <= dq_s[POS_W] ^ dyb_s[VAL_W] ^ dx_s[POS_W];
          if (x0 == x1) begin
            // zero-width interval: hand back the lower point's values
            res_a      <= y0a;
            res_b      <= y0b;
            res_status <= tilu_pkg::ST_ZERO_WIDTH;
            state      <= S_DONE;
          end else begin
            state <= S_MULA;
          end
        end
        S_MULA: begin
          prod_a <= tilu_pkg::PROD_W'(dq_mag) * tilu_pkg::PROD_W'(dya_mag);
          state  <= S_MULB;
        end
        S_MULB: begin
          prod_b <= tilu_pkg::PROD_W'(dq_mag) * tilu_pkg::PROD_W'(dyb_mag);
          state  <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (done_a) begin
            res_a      <= finish_val(quot_a, y0a, neg_a);
            res_b      <= finish_val(quot_b, y0b, neg_b);
            res_status <= tilu_pkg::ST_OK;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // output register free or draining this cycle
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(tilu_pkg::M_TDATA_W - tilu_pkg::M_FIELD_W)'(0),
                         lo_ext[tilu_pkg::LP_W-1:0], res_b, res_a};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------- assertions ----------------
  `TILU_ASSERT_IMP(a_search_order, (state == S_SEARCH) || (state == S_SWAIT), hi > lo,
    "search interval collapsed")
  `TILU_ASSERT_IMP(a_div_lockstep, done_a || done_b, done_a && done_b,
    "column dividers out of step")
  `TILU_ASSERT_NXT(a_zero_width, (state == S_PREP) && (x0 == x1), state == S_DONE,
    "zero-width interval reached the multiplier")
  `TILU_ASSERT_NXT(a_hold_result, (state == S_DONE) && m_tvalid && !m_tready,
    (state == S_DONE) && m_tvalid, "pending result overwritten")

endmodule
